// ===== src/pwsa_pkg.sv =====
// ----------------------------------------------------------------------------
// pwsa_pkg: shared types and codes of the page window slot allocator
// Request codes, status codes and the result bundle passed from the
// sequencer to the output stage.
// ----------------------------------------------------------------------------
package pwsa_pkg;

    localparam int SLOT_COUNT_DEF = 256;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int ADDR_W = 32;
    localparam int REF_W  = 32;
    localparam int IDX_OUT_W = 8;

    localparam logic [1:0] FUNC_MAP       = 2'd0;
    localparam logic [1:0] FUNC_UNMAP_REF = 2'd1;
    localparam logic [1:0] FUNC_UNMAP_VA  = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_BADARG   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]    mapped_addr;
        logic [IDX_OUT_W-1:0] slot_index;
        logic [1:0]           status;
    } result_t;

endpackage

// ===== src/pwsa_slot_ram.sv =====
// ----------------------------------------------------------------------------
// pwsa_slot_ram: slot table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pwsa_slot_ram #(
    parameter int DEPTH  = pwsa_pkg::SLOT_COUNT_DEF,
    parameter int ADDR_W = $clog2(pwsa_pkg::SLOT_COUNT_DEF)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [pwsa_pkg::REF_W-1:0] wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [pwsa_pkg::REF_W-1:0] rdata
);
    import pwsa_pkg::*;

    logic [REF_W-1:0] mem_reg [DEPTH];
    logic [REF_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pwsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwsa_ctrl: request sequencer
// Clears the slot table after reset, then walks it one slot per cycle
// through a single compare unit for map and unmap-by-reference, or reads
// one slot for unmap-by-address. Keeps the free count and first-free hint.
// ----------------------------------------------------------------------------
module pwsa_ctrl #(
    parameter int SLOT_COUNT = pwsa_pkg::SLOT_COUNT_DEF,
    parameter int PAGE_SHIFT = pwsa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           in_func,
    input  logic [pwsa_pkg::REF_W-1:0]           in_page_ref,
    input  logic [pwsa_pkg::ADDR_W-1:0]          in_virt_addr,
    input  logic [pwsa_pkg::ADDR_W-1:0]          window_base,
    output logic                                 ram_we,
    output logic [$clog2(SLOT_COUNT)-1:0]        ram_waddr,
    output logic [pwsa_pkg::REF_W-1:0]           ram_wdata,
    output logic                                 ram_re,
    output logic [$clog2(SLOT_COUNT)-1:0]        ram_raddr,
    input  logic [pwsa_pkg::REF_W-1:0]           ram_rdata,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output pwsa_pkg::result_t                    res
);
    import pwsa_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int FC_W  = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
    localparam logic [FC_W-1:0]  FULL_FREE = FC_W'(SLOT_COUNT);

    typedef enum logic [5:0] {
        ST_CLEAR    = 6'b000001,
        ST_IDLE     = 6'b000010,
        ST_DISPATCH = 6'b000100,
        ST_SCAN     = 6'b001000,
        ST_ADDR_CHK = 6'b010000,
        ST_RESP     = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [1:0]        func_reg, func_next;
    logic [REF_W-1:0]  ref_reg, ref_next;
    logic [ADDR_W-1:0] va_reg, va_next;
    logic [FC_W-1:0]   free_cnt_reg, free_cnt_next;
    logic [IDX_W-1:0]  hint_reg, hint_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              res_addr_ok_reg, res_addr_ok_next;

    logic [REF_W-1:0]  key;
    logic              is_map;
    logic              hit;
    logic [ADDR_W:0]   va_diff;
    logic [ADDR_W-1:0] va_page;
    logic              va_outside;
    logic [ADDR_W-1:0] res_idx_ext;

    assign is_map  = (func_reg == FUNC_MAP);
    assign key     = is_map ? '0 : ref_reg;
    assign hit     = (ram_rdata == key);

    // borrow out of the subtract flags an address below the window
    assign va_diff    = {1'b0, va_reg} - {1'b0, window_base};
    assign va_page    = va_diff[ADDR_W-1:0] >> PAGE_SHIFT;
    assign va_outside = va_diff[ADDR_W] || (va_page >= ADDR_W'(SLOT_COUNT));

    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        cmp_vld_next     = cmp_vld_reg;
        cmp_idx_next     = cmp_idx_reg;
        func_next        = func_reg;
        ref_next         = ref_reg;
        va_next          = va_reg;
        free_cnt_next    = free_cnt_reg;
        hint_next        = hint_reg;
        res_idx_next     = res_idx_reg;
        res_status_next  = res_status_reg;
        res_addr_ok_next = res_addr_ok_reg;
        ram_we           = 1'b0;
        ram_waddr        = cmp_idx_reg;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = ptr_reg;
        in_ready         = 1'b0;
        res_valid        = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                if (ptr_reg == LAST_IDX)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    func_next  = in_func;
                    ref_next   = in_page_ref;
                    va_next    = in_virt_addr;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                res_idx_next     = '0;
                res_addr_ok_next = 1'b0;
                cmp_vld_next     = 1'b0;
                state_next       = ST_RESP;
                case (func_reg)
                    FUNC_MAP:
                    begin
                        if (ref_reg == '0)
                        begin
                            res_status_next = STAT_BADARG;
                        end
                        else if (free_cnt_reg == '0)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            ptr_next   = hint_reg;
                            state_next = ST_SCAN;
                        end
                    end
                    FUNC_UNMAP_REF:
                    begin
                        if (ref_reg == '0)
                        begin
                            res_status_next = STAT_BADARG;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    FUNC_UNMAP_VA:
                    begin
                        if (va_outside)
                        begin
                            res_status_next = STAT_BADARG;
                        end
                        else
                        begin
                            ram_re       = 1'b1;
                            ram_raddr    = va_page[IDX_W-1:0];
                            cmp_idx_next = va_page[IDX_W-1:0];
                            state_next   = ST_ADDR_CHK;
                        end
                    end
                    default:
                    begin
                        res_status_next = STAT_BADARG;
                    end
                endcase
            end

            ST_SCAN:
            begin
                if (cmp_vld_reg && hit)
                begin
                    ram_we           = 1'b1;
                    ram_wdata        = is_map ? ref_reg : '0;
                    cmp_vld_next     = 1'b0;
                    res_idx_next     = cmp_idx_reg;
                    res_status_next  = STAT_OK;
                    res_addr_ok_next = 1'b1;
                    state_next       = ST_RESP;
                    if (is_map)
                    begin
                        free_cnt_next = free_cnt_reg - 1'b1;
                        hint_next     = cmp_idx_reg;
                    end
                    else
                    begin
                        if (free_cnt_reg < FULL_FREE)
                        begin
                            free_cnt_next = free_cnt_reg + 1'b1;
                        end
                        if (cmp_idx_reg < hint_reg)
                        begin
                            hint_next = cmp_idx_reg;
                        end
                    end
                end
                else if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    cmp_vld_next     = 1'b0;
                    res_idx_next     = '0;
                    res_status_next  = is_map ? STAT_FULL : STAT_NOTFOUND;
                    res_addr_ok_next = 1'b0;
                    state_next       = ST_RESP;
                end
                else
                begin
                    ram_re       = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = ptr_reg;
                    ptr_next     = ptr_reg + 1'b1;
                end
            end

            ST_ADDR_CHK:
            begin
                res_idx_next     = cmp_idx_reg;
                res_addr_ok_next = 1'b1;
                state_next       = ST_RESP;
                if (ram_rdata == '0)
                begin
                    res_status_next = STAT_NOTFOUND;
                end
                else
                begin
                    ram_we          = 1'b1;
                    res_status_next = STAT_OK;
                    if (free_cnt_reg < FULL_FREE)
                    begin
                        free_cnt_next = free_cnt_reg + 1'b1;
                    end
                    if (cmp_idx_reg < hint_reg)
                    begin
                        hint_next = cmp_idx_reg;
                    end
                end
            end

            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_idx_ext     = ADDR_W'(res_idx_reg);
    assign res.status      = res_status_reg;
    assign res.slot_index  = res_idx_ext[IDX_OUT_W-1:0];
    assign res.mapped_addr = res_addr_ok_reg ? (window_base + (res_idx_ext << PAGE_SHIFT))
                                             : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            ptr_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            free_cnt_reg <= FULL_FREE;
            hint_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            cmp_vld_reg  <= cmp_vld_next;
            free_cnt_reg <= free_cnt_next;
            hint_reg     <= hint_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg     <= cmp_idx_next;
        func_reg        <= func_next;
        ref_reg         <= ref_next;
        va_reg          <= va_next;
        res_idx_reg     <= res_idx_next;
        res_status_reg  <= res_status_next;
        res_addr_ok_reg <= res_addr_ok_next;
    end

    a_free_max: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= FULL_FREE)
        else $error("free count above slot count");

    a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg <= LAST_IDX)
        else $error("first-free hint outside table");

    a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) && (state_next != ST_CLEAR) |=> (state_reg == ST_IDLE))
        else $error("clear pass did not end in idle");

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP) && !res_ready |=> (state_reg == ST_RESP) && $stable(res))
        else $error("result dropped before transfer");

endmodule

// ===== src/page_window_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// page_window_slot_allocator: mapping slot allocator for a virtual window
// Maps page references into the first free slot at or after a hint and
// frees slots by reference or by virtual address.
//
//   channel  signals                               direction  payload
//   cfg      cfg_valid / cfg_ready                 in         cfg_data (window base)
//   in       in_valid / in_ready                   in         func, page_ref, virt_addr
//   out      out_valid / out_ready                 out        mapped_addr, slot_index, status
//
// map and unmap-by-reference walk the table one slot per cycle through
// one compare unit on the single read port.
// unmap-by-address reads a single slot; rejected requests skip the table.
// after reset a clearing pass empties the table; in_ready
// stays low meanwhile, cfg transfers are taken at any time.
// one request at a time; the next is taken while a result waits in the
// output register, a stalled out channel holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module page_window_slot_allocator #(
    parameter int SLOT_COUNT = pwsa_pkg::SLOT_COUNT_DEF,
    parameter int PAGE_SHIFT = pwsa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pwsa_pkg::ADDR_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic [pwsa_pkg::REF_W-1:0]        page_ref,
    input  logic [pwsa_pkg::ADDR_W-1:0]       virt_addr,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pwsa_pkg::ADDR_W-1:0]       mapped_addr,
    output logic [pwsa_pkg::IDX_OUT_W-1:0]    slot_index,
    output logic [1:0]                        status
);
    import pwsa_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);

    logic [ADDR_W-1:0] window_base_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [REF_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [REF_W-1:0]  ram_rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || out_ready;

    pwsa_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_func      (func),
        .in_page_ref  (page_ref),
        .in_virt_addr (virt_addr),
        .window_base  (window_base_reg),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    pwsa_slot_ram #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                window_base_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mapped_addr = out_res_reg.mapped_addr;
    assign slot_index  = out_res_reg.slot_index;
    assign status      = out_res_reg.status;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the page window slot allocator
// Drives map and unmap requests over the valid/ready request channel, writes
// the window base between phases and checks every result, field by field, against a
// directed expectation or an in-bench model of the slot table, free count and first-free hint.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pwsa_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int PG_SHIFT     = PAGE_SHIFT_DEF;
    localparam int PAGE_BYTES   = 1 << PG_SHIFT;
    localparam int POOL_SIZE    = 12;
    localparam int DIR_ROWS     = 20;
    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_GAP      = 40;

    localparam logic [1:0] FUNC_BAD = 2'd3;

    typedef struct {
        logic [1:0]  f;
        logic [31:0] pref;
        logic [31:0] va;
        bit          typed;
        result_t     want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [ADDR_W-1:0]    cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [1:0]           func        = FUNC_MAP;
    logic [REF_W-1:0]     page_ref    = '0;
    logic [ADDR_W-1:0]    virt_addr   = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [ADDR_W-1:0]    mapped_addr;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [1:0]           status;

    // in-bench copy of the allocator state
    logic [31:0] slot_refs [SLOTS];
    int          free_slots = SLOTS;
    int          alloc_hint = 0;
    logic [31:0] win_base   = 32'h0;

    result_t     pending_results [$];
    logic [31:0] ref_pool [POOL_SIZE];
    dir_row_t    dir_rows [DIR_ROWS];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatches     = 0;
    int          results_seen   = 0;
    int          quiet_cycles   = 0;

    page_window_slot_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .page_ref    (page_ref),
        .virt_addr   (virt_addr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mapped_addr (mapped_addr),
        .slot_index  (slot_index),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] slot_va(int idx);
        return win_base + (32'(idx) << PG_SHIFT);
    endfunction

    function automatic void free_slot(int idx);
        slot_refs[idx] = 32'h0;
        if (free_slots < SLOTS)
            free_slots++;
        if (idx < alloc_hint)
            alloc_hint = idx;
    endfunction

    function automatic result_t predict_alloc_result(logic [1:0] f, logic [31:0] pref,
                                                     logic [31:0] va);
        result_t     r;
        logic [31:0] off;
        int          hit;
        r   = '{32'h0, 8'd0, STAT_BADARG};
        hit = -1;
        case (f)
            FUNC_MAP:
            begin
                if (pref != 32'h0)
                begin
                    r.status = STAT_FULL;
                    if (free_slots != 0)
                        for (int i = alloc_hint; i < SLOTS && hit < 0; i++)
                            if (slot_refs[i] == 32'h0)
                                hit = i;
                    if (hit >= 0)
                    begin
                        slot_refs[hit] = pref;
                        free_slots--;
                        alloc_hint = hit;
                        r = '{slot_va(hit), 8'(hit), STAT_OK};
                    end
                end
            end
            FUNC_UNMAP_REF:
            begin
                if (pref != 32'h0)
                begin
                    r.status = STAT_NOTFOUND;
                    for (int i = 0; i < SLOTS && hit < 0; i++)
                        if (slot_refs[i] == pref)
                            hit = i;
                    if (hit >= 0)
                    begin
                        free_slot(hit);
                        r = '{slot_va(hit), 8'(hit), STAT_OK};
                    end
                end
            end
            FUNC_UNMAP_VA:
            begin
                off = va - win_base;
                if (va >= win_base && (off >> PG_SHIFT) < SLOTS)
                begin
                    hit = int'(off >> PG_SHIFT);
                    r = '{slot_va(hit), 8'(hit), STAT_NOTFOUND};
                    if (slot_refs[hit] != 32'h0)
                    begin
                        free_slot(hit);
                        r.status = STAT_OK;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h (result %0d)",
                 what, got, want, results_seen);
        mismatches++;
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", mapped_addr, 32'h0);
            else
            begin
                want = pending_results.pop_front();
                if (mapped_addr !== want.mapped_addr)
                    report_mismatch("mapped_addr", mapped_addr, want.mapped_addr);
                if (slot_index !== want.slot_index)
                    report_mismatch("slot_index", 32'(slot_index), 32'(want.slot_index));
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
            end
            results_seen++;
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_req(input logic [1:0] f, input logic [31:0] pref,
                            input logic [31:0] va, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        page_ref  <= pref;
        virt_addr <= va;
        do @(posedge clk); while (!in_ready);
        predicted = predict_alloc_result(f, pref, va);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_window_base(input logic [31:0] base);
        drain_results();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_base = base;
    endtask

    task automatic pick_request(output logic [1:0] f, output logic [31:0] pref,
                                output logic [31:0] va);
        int roll;
        int s;
        roll = $urandom_range(99);
        pref = ref_pool[$urandom_range(POOL_SIZE - 1)];
        va   = $urandom;
        s    = $urandom_range(SLOTS - 1);
        f    = FUNC_UNMAP_VA;
        if (roll < 40)
            f = FUNC_MAP;
        else if (roll < 44)
        begin
            f    = FUNC_MAP;
            pref = (roll == 40) ? 32'h0 : $urandom;
        end
        else if (roll < 64)
            f = FUNC_UNMAP_REF;
        else if (roll < 68)
        begin
            f    = FUNC_UNMAP_REF;
            pref = (roll == 64) ? 32'h0 : $urandom;
        end
        else if (roll < 92)
        begin
            // half the time aim at an occupied slot
            if (roll < 80)
                for (int k = 0; k < SLOTS && slot_refs[s] == 32'h0; k++)
                    s = (s + 1) % SLOTS;
            va = win_base + (32'(s) << PG_SHIFT) + 32'($urandom_range(PAGE_BYTES - 1));
        end
        else if (roll == 92)
            va = win_base - 32'h1;
        else if (roll == 93)
            va = win_base + (32'(SLOTS) << PG_SHIFT);
        else if (roll == 94)
            va = win_base + (32'(SLOTS) << PG_SHIFT) - 32'h1;
        else if (roll >= 97)
            f = FUNC_BAD;
    endtask

    task automatic run_random(input int count, input int pause_at);
        logic [1:0]  f;
        logic [31:0] pref;
        logic [31:0] va;
        for (int k = 0; k < count; k++)
        begin
            if (k == pause_at)
                drain_results();
            pick_request(f, pref, va);
            send_req(f, pref, va, 1'b0, '0);
        end
    endtask

    initial
    begin
        logic [31:0] v;
        for (int i = 0; i < SLOTS; i++)
            slot_refs[i] = 32'h0;
        ref_pool[0] = 32'hFFFF_FFFF;
        ref_pool[1] = 32'h0000_0001;
        ref_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_SIZE; i++)
        begin
            do v = $urandom; while (v == 32'h0);
            ref_pool[i] = v;
        end

        dir_rows = '{
            '{FUNC_MAP,       32'h0,         32'h0,         1'b1,
              '{32'h0, 8'd0, STAT_BADARG}},
            '{FUNC_UNMAP_REF, 32'h0,         32'hFFFF_FFFF, 1'b1,
              '{32'h0, 8'd0, STAT_BADARG}},
            '{FUNC_BAD,       32'h0,         32'h0,         1'b1,
              '{32'h0, 8'd0, STAT_BADARG}},
            '{FUNC_UNMAP_REF, 32'h1234_5678, 32'h0,         1'b1,
              '{32'h0, 8'd0, STAT_NOTFOUND}},
            '{FUNC_UNMAP_VA,  32'h0,         32'h0000_5ABC, 1'b1,
              '{32'h0000_5000, 8'd5, STAT_NOTFOUND}},
            '{FUNC_UNMAP_VA,  32'h0,         32'h0010_0000, 1'b1,
              '{32'h0, 8'd0, STAT_BADARG}},
            '{FUNC_UNMAP_VA,  32'h0,         32'hFFFF_FFFF, 1'b1,
              '{32'h0, 8'd0, STAT_BADARG}},
            '{FUNC_UNMAP_VA,  32'h0,         32'h000F_FFFF, 1'b1,
              '{32'h000F_F000, 8'd255, STAT_NOTFOUND}},
            '{FUNC_MAP,       32'hFFFF_FFFF, 32'h0,         1'b1,
              '{32'h0, 8'd0, STAT_OK}},
            '{FUNC_MAP,       32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0},
            '{FUNC_MAP,       32'hAAAA_5555, 32'h0,         1'b0, '0},
            '{FUNC_MAP,       32'h5555_AAAA, 32'h0,         1'b0, '0},
            '{FUNC_UNMAP_REF, 32'h0000_0001, 32'h0,         1'b0, '0},
            '{FUNC_MAP,       32'h8000_0000, 32'h0,         1'b0, '0},
            '{FUNC_UNMAP_VA,  32'h0,         32'h0000_0FFF, 1'b0, '0},
            '{FUNC_UNMAP_VA,  32'h0,         32'h0000_0000, 1'b0, '0},
            '{FUNC_MAP,       32'hFFFF_FFFF, 32'h0,         1'b0, '0},
            '{FUNC_MAP,       32'hFFFF_FFFF, 32'h0,         1'b0, '0},
            '{FUNC_UNMAP_REF, 32'hFFFF_FFFF, 32'h0,         1'b0, '0},
            '{FUNC_BAD,       32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{32'h0, 8'd0, STAT_BADARG}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests at the reset window base
        for (int i = 0; i < DIR_ROWS; i++)
            send_req(dir_rows[i].f, dir_rows[i].pref, dir_rows[i].va,
                     dir_rows[i].typed, dir_rows[i].want);

        // window at the top of the address space, sender idling
        send_idle_pct = 52;
        write_window_base(32'hFFFF_F000);
        run_random(120, -1);

        // fill the table to full at base zero, receiver stalling
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        write_window_base(32'h0);
        while (free_slots != 0)
            send_req(FUNC_MAP, ref_pool[$urandom_range(POOL_SIZE - 1)], $urandom, 1'b0, '0);
        repeat (6)
            send_req(FUNC_MAP, $urandom | 32'h1, $urandom, 1'b0, '0);
        run_random(80, -1);

        // random window, both sides idling, one full drain midway
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        write_window_base($urandom & 32'hFFFF_F000);
        run_random(120, 60);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_window_base($urandom & 32'hFFFF_F000);
        run_random(120, -1);

        drain_results();
        repeat (SLOTS + 16) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
